// ===== src/sbfe_pkg.sv =====
// Shared types, codes and constants for the servo bus frame engine.
`timescale 1ns / 1ps
`default_nettype none
package sbfe_pkg;

  // Frame marker bytes
  localparam logic [7:0] BYTE_MARK  = 8'hAA;
  localparam logic [7:0] BYTE_HDR   = 8'h55;
  localparam logic [7:0] BYTE_TAIL  = 8'h81;
  localparam logic [7:0] BYTE_STUFF = 8'h00;

  // Length bytes: request frames and expected replies
  localparam logic [7:0] REQ_LEN_READ  = 8'd8;
  localparam logic [7:0] REQ_LEN_WRITE = 8'd10;
  localparam logic [4:0] RSP_LEN_READ  = 5'd10;
  localparam logic [4:0] RSP_LEN_WRITE = 5'd9;

  // Reply capture store
  localparam int REPLY_DEPTH = 16;
  localparam int REPLY_IDX_W = $clog2(REPLY_DEPTH);
  localparam int REPLY_CNT_W = 5;
  localparam logic [REPLY_CNT_W-1:0] REPLY_CNT_MAX = '1;

  // Transmit body: up to ten bytes including checksum
  localparam int BODY_LEN = 10;
  localparam logic [3:0] BODY_LAST_READ  = 4'd7;
  localparam logic [3:0] BODY_LAST_WRITE = 4'd9;

  // Request types on in_tuser
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_BYTE  = 2'd2;

  // Result kinds on out_tuser
  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_OUTCOME = 1'b1;

  // Outcome status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_REFUSED  = 3'd1;
  localparam logic [2:0] ST_BAD_SUM  = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_ADDR     = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_MASTER    = 3'd0;
  localparam logic [2:0] CFG_BROADCAST = 3'd1;
  localparam logic [2:0] CFG_READ_OP   = 3'd2;
  localparam logic [2:0] CFG_WRITE_OP  = 3'd3;
  localparam logic [2:0] CFG_ANSWER_OP = 3'd4;
  localparam logic [2:0] CFG_OK_CODE   = 3'd5;

  typedef struct packed {
    logic [15:0] master_address;
    logic [15:0] broadcast_address;
    logic [7:0]  read_opcode;
    logic [7:0]  write_opcode;
    logic [7:0]  answer_opcode;
    logic [7:0]  ok_code;
  } cfg_t;

  // Work handed from the request/receive side to the transmit side
  typedef struct packed {
    logic        load_outcome;
    logic        load_frame;
    logic [2:0]  status;
    logic [15:0] value;
    logic [15:0] device;
    logic [7:0]  register_address;
    logic [15:0] write_value;
    logic        is_write;
  } pkt_t;

endpackage
`default_nettype wire

// ===== src/sbfe_cfg.sv =====
// Configuration register bank of the servo bus frame engine.
`timescale 1ns / 1ps
`default_nettype none
module sbfe_cfg
  import sbfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.master_address    <= 16'd1;
      cfg_r.broadcast_address <= 16'hFFFF;
      cfg_r.read_opcode       <= 8'd1;
      cfg_r.write_opcode      <= 8'd2;
      cfg_r.answer_opcode     <= 8'd3;
      cfg_r.ok_code           <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MASTER:    cfg_r.master_address    <= cfg_wdata;
        CFG_BROADCAST: cfg_r.broadcast_address <= cfg_wdata;
        CFG_READ_OP:   cfg_r.read_opcode       <= cfg_wdata[7:0];
        CFG_WRITE_OP:  cfg_r.write_opcode      <= cfg_wdata[7:0];
        CFG_ANSWER_OP: cfg_r.answer_opcode     <= cfg_wdata[7:0];
        CFG_OK_CODE:   cfg_r.ok_code           <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== src/sbfe_rx.sv =====
// Request check, reply deframing/destuffing and reply judgment.
`timescale 1ns / 1ps
`default_nettype none
module sbfe_rx
  import sbfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cfg_t             cfg,
  input  wire logic        accept,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] device_address,
  input  wire logic [7:0]  register_address,
  input  wire logic [15:0] write_value,
  input  wire logic [7:0]  received_byte,
  output pkt_t             pkt
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HUNT = 2'd1;
  localparam logic [1:0] PH_SYNC = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  logic [1:0]             phase_r, phase_nxt;
  logic                   esc_r, esc_nxt;
  logic [REPLY_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]            pend_dev_r, pend_dev_nxt;
  logic [7:0]             pend_reg_r, pend_reg_nxt;
  logic                   pend_wr_r, pend_wr_nxt;
  logic [7:0]             reply_r [REPLY_DEPTH];

  logic       store_en;
  logic [7:0] store_byte;
  logic       addr_ok;
  logic       is_write;

  // Reply judgment
  logic [4:0]  need;
  logic        fields_ok;
  logic [7:0]  sum_rd, sum_wr, sum_calc, sum_rx;
  logic [2:0]  judge_status;
  logic [15:0] judge_value;

  always_comb begin
    need      = pend_wr_r ? RSP_LEN_WRITE : RSP_LEN_READ;
    fields_ok = ({reply_r[0], reply_r[1]} == pend_dev_r) &&
                ({reply_r[2], reply_r[3]} == cfg.master_address) &&
                (reply_r[4] == {3'b000, need}) &&
                (reply_r[5] == cfg.answer_opcode) &&
                (reply_r[6] == pend_reg_r);
    sum_wr   = reply_r[0] ^ reply_r[1] ^ reply_r[2] ^ reply_r[3] ^
               reply_r[4] ^ reply_r[5] ^ reply_r[6] ^ reply_r[7];
    sum_rd   = sum_wr ^ reply_r[8];
    sum_calc = pend_wr_r ? sum_wr : sum_rd;
    sum_rx   = pend_wr_r ? reply_r[8] : reply_r[9];
    judge_value = '0;
    if (cnt_r < need || !fields_ok) begin
      judge_status = ST_MISMATCH;
    end else if (sum_calc != sum_rx) begin
      judge_status = ST_BAD_SUM;
    end else if (pend_wr_r) begin
      judge_status = (reply_r[7] == cfg.ok_code) ? ST_OK : ST_REFUSED;
    end else begin
      judge_status = ST_OK;
      judge_value  = {reply_r[7], reply_r[8]};
    end
  end

  assign is_write = (req_type == REQ_WRITE);
  assign addr_ok  = (device_address > cfg.master_address) &&
                    (is_write ? (device_address <= cfg.broadcast_address)
                              : (device_address <  cfg.broadcast_address));

  always_comb begin
    phase_nxt    = phase_r;
    esc_nxt      = esc_r;
    cnt_nxt      = cnt_r;
    pend_dev_nxt = pend_dev_r;
    pend_reg_nxt = pend_reg_r;
    pend_wr_nxt  = pend_wr_r;
    store_en     = 1'b0;
    store_byte   = received_byte;
    pkt          = '0;
    pkt.device           = device_address;
    pkt.register_address = register_address;
    pkt.write_value      = write_value;
    pkt.is_write         = is_write;

    if (accept) begin
      if (req_type == REQ_READ || req_type == REQ_WRITE) begin
        if (!addr_ok) begin
          pkt.load_outcome = 1'b1;
          pkt.status       = ST_ADDR;
        end else begin
          pkt.load_frame = 1'b1;
          esc_nxt        = 1'b0;
          cnt_nxt        = '0;
          if (is_write && device_address == cfg.broadcast_address) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt    = PH_HUNT;
            pend_dev_nxt = device_address;
            pend_reg_nxt = register_address;
            pend_wr_nxt  = is_write;
          end
        end
      end else if (req_type == REQ_BYTE) begin
        unique case (phase_r)
          PH_HUNT: begin
            if (received_byte == BYTE_MARK) phase_nxt = PH_SYNC;
          end
          PH_SYNC: begin
            if (received_byte == BYTE_HDR) begin
              phase_nxt = PH_BODY;
              cnt_nxt   = '0;
              esc_nxt   = 1'b0;
            end else if (received_byte != BYTE_MARK) begin
              phase_nxt = PH_HUNT;
            end
          end
          PH_BODY: begin
            if (esc_r) begin
              esc_nxt = 1'b0;
              if (received_byte == BYTE_STUFF) begin
                store_en   = 1'b1;
                store_byte = BYTE_MARK;
              end else begin
                phase_nxt        = PH_IDLE;
                pkt.load_outcome = 1'b1;
                if (received_byte == BYTE_TAIL) begin
                  pkt.status = judge_status;
                  pkt.value  = judge_value;
                end else begin
                  pkt.status = ST_MISMATCH;
                end
              end
            end else if (received_byte == BYTE_MARK) begin
              esc_nxt = 1'b1;
            end else begin
              store_en = 1'b1;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
        if (store_en && cnt_r != REPLY_CNT_MAX) cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      esc_r      <= 1'b0;
      cnt_r      <= '0;
      pend_dev_r <= '0;
      pend_reg_r <= '0;
      pend_wr_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      esc_r      <= esc_nxt;
      cnt_r      <= cnt_nxt;
      pend_dev_r <= pend_dev_nxt;
      pend_reg_r <= pend_reg_nxt;
      pend_wr_r  <= pend_wr_nxt;
    end
  end

  // Bytes past the store depth are dropped; the count keeps going until it saturates
  always_ff @(posedge clk) begin
    if (store_en && ({1'b0, cnt_r} < (REPLY_CNT_W + 1)'(REPLY_DEPTH))) begin
      reply_r[cnt_r[REPLY_IDX_W-1:0]] <= store_byte;
    end
  end

endmodule
`default_nettype wire

// ===== src/sbfe_tx.sv =====
// Frame byte generator with stuffing, and the result output register.
`timescale 1ns / 1ps
`default_nettype none
module sbfe_tx
  import sbfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cfg_t             cfg,
  input  pkt_t             pkt,
  output logic             take_ok,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       transmit_byte,
  output logic             frame_end,
  output logic [2:0]       outcome_status,
  output logic [15:0]      reply_value
);

  localparam logic [1:0] GEN_HDR  = 2'd0;
  localparam logic [1:0] GEN_BODY = 2'd1;
  localparam logic [1:0] GEN_MARK = 2'd2;
  localparam logic [1:0] GEN_TAIL = 2'd3;

  logic        out_valid_r, out_valid_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        end_r, end_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [15:0] value_r, value_nxt;

  logic        busy_r, busy_nxt;
  logic [1:0]  gen_r, gen_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  last_r, last_nxt;
  logic        stuff_r, stuff_nxt;
  logic [7:0]  body_r [BODY_LEN];
  logic [7:0]  body_new [BODY_LEN];
  logic [7:0]  sum;
  logic        slot_free;
  logic [7:0]  cur;

  assign slot_free = !out_valid_r || out_ready;
  assign take_ok   = !busy_r && slot_free;
  assign cur       = body_r[idx_r];

  always_comb begin
    body_new[0] = cfg.master_address[15:8];
    body_new[1] = cfg.master_address[7:0];
    body_new[2] = pkt.device[15:8];
    body_new[3] = pkt.device[7:0];
    body_new[4] = pkt.is_write ? REQ_LEN_WRITE : REQ_LEN_READ;
    body_new[5] = pkt.is_write ? cfg.write_opcode : cfg.read_opcode;
    body_new[6] = pkt.register_address;
    sum = body_new[0] ^ body_new[1] ^ body_new[2] ^ body_new[3] ^
          body_new[4] ^ body_new[5] ^ body_new[6];
    if (pkt.is_write) begin
      body_new[7] = pkt.write_value[15:8];
      body_new[8] = pkt.write_value[7:0];
      body_new[9] = sum ^ pkt.write_value[15:8] ^ pkt.write_value[7:0];
    end else begin
      body_new[7] = sum;
      body_new[8] = '0;
      body_new[9] = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    end_nxt       = end_r;
    status_nxt    = status_r;
    value_nxt     = value_r;
    busy_nxt      = busy_r;
    gen_nxt       = gen_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    stuff_nxt     = stuff_r;

    priority if (pkt.load_outcome) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_OUTCOME;
      byte_nxt      = '0;
      end_nxt       = 1'b0;
      status_nxt    = pkt.status;
      value_nxt     = pkt.value;
    end else if (pkt.load_frame) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_TX;
      byte_nxt      = BYTE_MARK;
      end_nxt       = 1'b0;
      status_nxt    = ST_OK;
      value_nxt     = '0;
      busy_nxt      = 1'b1;
      gen_nxt       = GEN_HDR;
      idx_nxt       = '0;
      stuff_nxt     = 1'b0;
      last_nxt      = pkt.is_write ? BODY_LAST_WRITE : BODY_LAST_READ;
    end else if (busy_r && slot_free) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_TX;
      end_nxt       = 1'b0;
      status_nxt    = ST_OK;
      value_nxt     = '0;
      unique case (gen_r)
        GEN_HDR: begin
          byte_nxt = BYTE_HDR;
          gen_nxt  = GEN_BODY;
        end
        GEN_BODY: begin
          if (stuff_r || cur != BYTE_MARK) begin
            byte_nxt  = stuff_r ? BYTE_STUFF : cur;
            stuff_nxt = 1'b0;
            if (idx_r == last_r) gen_nxt = GEN_MARK;
            else idx_nxt = idx_r + 1'b1;
          end else begin
            // marker byte inside the body: send it, stuff a zero next
            byte_nxt  = cur;
            stuff_nxt = 1'b1;
          end
        end
        GEN_MARK: begin
          byte_nxt = BYTE_MARK;
          gen_nxt  = GEN_TAIL;
        end
        GEN_TAIL: begin
          byte_nxt = BYTE_TAIL;
          end_nxt  = 1'b1;
          busy_nxt = 1'b0;
        end
        default: busy_nxt = 1'b0;
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      gen_r       <= GEN_HDR;
      idx_r       <= '0;
      stuff_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      gen_r       <= gen_nxt;
      idx_r       <= idx_nxt;
      stuff_r     <= stuff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    byte_r   <= byte_nxt;
    end_r    <= end_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
    last_r   <= last_nxt;
    if (pkt.load_frame) begin
      for (int i = 0; i < BODY_LEN; i++) begin
        body_r[i] <= body_new[i];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign transmit_byte  = byte_r;
  assign frame_end      = end_r;
  assign outcome_status = status_r;
  assign reply_value    = value_r;

endmodule
`default_nettype wire

// ===== src/servo_bus_frame_engine_unit.sv =====
// Top level of the servo bus frame engine: request framing and reply checking.
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready   tuser req_type, tdata request/byte fields
//  out_     out  out_tvalid/out_tready tuser kind, tlast frame end, tdata fields
//  cfg_     in   cfg_we               cfg_addr index, cfg_wdata value
//
// A received byte or a rejected request does not occupy the byte generator;
// a result sits in the output register and the next transaction is taken in
// the same cycle it leaves. A sent frame (12 to 22 bytes) occupies the byte
// generator, which waits while the output is stalled, and no input is taken
// until its last byte is in the output register.
// Reset (rst_n low, synchronous) clears the receiver, generator and output valid.
`timescale 1ns / 1ps
`default_nettype none
module servo_bus_frame_engine_unit
  import sbfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // req_type
  // device_address[15:0], register_address[23:16], write_value[39:24],
  // received_byte[47:40]
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic             out_tuser,  // out_kind
  output logic             out_tlast,  // frame_end
  // transmit_byte[7:0], outcome_status[10:8], reply_value[26:11], zero pad
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  cfg_t        cfg;
  pkt_t        pkt;
  logic        take_ok;
  logic        in_fire;
  logic [7:0]  transmit_byte;
  logic [2:0]  outcome_status;
  logic [15:0] reply_value;

  assign in_tready = take_ok;
  assign in_fire   = in_tvalid && take_ok;

  sbfe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sbfe_rx u_rx (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .accept           (in_fire),
    .req_type         (in_tuser),
    .device_address   (in_tdata[15:0]),
    .register_address (in_tdata[23:16]),
    .write_value      (in_tdata[39:24]),
    .received_byte    (in_tdata[47:40]),
    .pkt              (pkt)
  );

  sbfe_tx u_tx (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .pkt            (pkt),
    .take_ok        (take_ok),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_kind       (out_tuser),
    .transmit_byte  (transmit_byte),
    .frame_end      (out_tlast),
    .outcome_status (outcome_status),
    .reply_value    (reply_value)
  );

  assign out_tdata = {5'b00000, reply_value, outcome_status, transmit_byte};

endmodule
`default_nettype wire
